// ===== rtl/mse_pkg.sv =====
package mse_pkg;

    // Opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // Function codes of the register form
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    // Operand source selects; any other code picks the memory forward
    localparam logic [1:0] SEL_REG = 2'd0;
    localparam logic [1:0] SEL_WB  = 2'd1;

    localparam logic [31:0] PC_STEP = 32'd4;

    typedef enum logic [3:0] {
        ALU_NONE = 4'd0,
        ALU_ADD  = 4'd1,
        ALU_SUB  = 4'd2,
        ALU_AND  = 4'd3,
        ALU_OR   = 4'd4,
        ALU_NOR  = 4'd5,
        ALU_SLTU = 4'd6,
        ALU_SLL  = 4'd7,
        ALU_SRL  = 4'd8,
        ALU_PASS = 4'd9
    } alu_op_t;

    typedef enum logic [1:0] {
        BR_NONE = 2'd0,
        BR_EQ   = 2'd1,
        BR_NE   = 2'd2
    } br_kind_t;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] instr_addr;
        logic [31:0] reg_value_a;
        logic [31:0] reg_value_b;
        logic [31:0] wb_forward_value;
        logic [31:0] mem_forward_value;
        logic [1:0]  select_a;
        logic [1:0]  select_b;
    } in_req_t;

    typedef struct packed {
        logic [31:0] alu_out;
        logic        branch_taken;
        logic [31:0] branch_addr;
        logic        jump_taken;
        logic [31:0] jump_addr;
        logic [31:0] store_data;
    } out_req_t;

    // Decoded request after operand selection
    typedef struct packed {
        logic [31:0] opnd_a;
        logic [31:0] opnd_b;
        logic [31:0] opnd_2;
        alu_op_t     alu_op;
        logic [4:0]  shamt;
        br_kind_t    br_kind;
        logic        jump_taken;
        logic [31:0] jump_addr;
        logic [31:0] next_addr;
        logic [31:0] br_offset;
    } dec_t;

    // Request after the ALU and branch arithmetic
    typedef struct packed {
        logic [31:0] alu_out;
        br_kind_t    br_kind;
        logic        equal;
        logic [31:0] branch_addr;
        logic        jump_taken;
        logic [31:0] jump_addr;
        logic [31:0] store_data;
    } exe_t;

endpackage

// ===== rtl/mse_operand_stage.sv =====
module mse_operand_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mse_pkg::in_req_t in_req,
    output logic            out_valid,
    input  logic            out_ready,
    output mse_pkg::dec_t   out_data
);

    logic          valid_reg;
    mse_pkg::dec_t data_reg;
    mse_pkg::dec_t data_next;

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [31:0] zx;
    logic [31:0] sx;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] next_addr;

    // Operand selection
    always_comb
    begin
        case (in_req.select_a)
            mse_pkg::SEL_REG: a = in_req.reg_value_a;
            mse_pkg::SEL_WB:  a = in_req.wb_forward_value;
            default:          a = in_req.mem_forward_value;
        endcase
        case (in_req.select_b)
            mse_pkg::SEL_REG: b = in_req.reg_value_b;
            mse_pkg::SEL_WB:  b = in_req.wb_forward_value;
            default:          b = in_req.mem_forward_value;
        endcase
    end

    assign op        = in_req.instr_word[31:26];
    assign fn        = in_req.instr_word[5:0];
    assign zx        = {16'h0000, in_req.instr_word[15:0]};
    assign sx        = {{16{in_req.instr_word[15]}}, in_req.instr_word[15:0]};
    assign next_addr = in_req.instr_addr + mse_pkg::PC_STEP;

    // Instruction decode
    always_comb
    begin
        data_next            = '0;
        data_next.opnd_a     = a;
        data_next.opnd_b     = b;
        data_next.opnd_2     = b;
        data_next.alu_op     = mse_pkg::ALU_NONE;
        data_next.shamt      = in_req.instr_word[10:6];
        data_next.br_kind    = mse_pkg::BR_NONE;
        data_next.jump_taken = 1'b0;
        data_next.jump_addr  = '0;
        data_next.next_addr  = next_addr;
        data_next.br_offset  = {sx[29:0], 2'b00};

        unique case (op) inside
            mse_pkg::OP_SPECIAL:
            begin
                unique case (fn)
                    mse_pkg::FN_JR:
                    begin
                        data_next.jump_taken = 1'b1;
                        data_next.jump_addr  = a;
                    end
                    mse_pkg::FN_ADDU: data_next.alu_op = mse_pkg::ALU_ADD;
                    mse_pkg::FN_SUBU: data_next.alu_op = mse_pkg::ALU_SUB;
                    mse_pkg::FN_AND:  data_next.alu_op = mse_pkg::ALU_AND;
                    mse_pkg::FN_OR:   data_next.alu_op = mse_pkg::ALU_OR;
                    mse_pkg::FN_NOR:  data_next.alu_op = mse_pkg::ALU_NOR;
                    mse_pkg::FN_SLTU: data_next.alu_op = mse_pkg::ALU_SLTU;
                    mse_pkg::FN_SLL:  data_next.alu_op = mse_pkg::ALU_SLL;
                    mse_pkg::FN_SRL:  data_next.alu_op = mse_pkg::ALU_SRL;
                    default:          data_next.alu_op = mse_pkg::ALU_NONE;
                endcase
            end
            mse_pkg::OP_J, mse_pkg::OP_JAL:
            begin
                data_next.jump_taken = 1'b1;
                data_next.jump_addr  = {next_addr[31:28], in_req.instr_word[25:0], 2'b00};
            end
            mse_pkg::OP_BEQ: data_next.br_kind = mse_pkg::BR_EQ;
            mse_pkg::OP_BNE: data_next.br_kind = mse_pkg::BR_NE;
            mse_pkg::OP_ADDIU, mse_pkg::OP_LW, mse_pkg::OP_SW:
            begin
                data_next.alu_op = mse_pkg::ALU_ADD;
                data_next.opnd_2 = sx;
            end
            mse_pkg::OP_SLTIU:
            begin
                data_next.alu_op = mse_pkg::ALU_SLTU;
                data_next.opnd_2 = sx;
            end
            mse_pkg::OP_ANDI:
            begin
                data_next.alu_op = mse_pkg::ALU_AND;
                data_next.opnd_2 = zx;
            end
            mse_pkg::OP_ORI:
            begin
                data_next.alu_op = mse_pkg::ALU_OR;
                data_next.opnd_2 = zx;
            end
            mse_pkg::OP_LUI:
            begin
                data_next.alu_op = mse_pkg::ALU_PASS;
                data_next.opnd_2 = {in_req.instr_word[15:0], 16'h0000};
            end
            default: data_next.alu_op = mse_pkg::ALU_NONE;
        endcase
    end

    // Stage handshake: load when empty or when the next stage takes ours
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/mse_alu_stage.sv =====
module mse_alu_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mse_pkg::dec_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output mse_pkg::exe_t out_data
);

    logic          valid_reg;
    mse_pkg::exe_t data_reg;
    mse_pkg::exe_t data_next;
    logic [31:0]   alu_value;

    // ALU
    always_comb
    begin
        case (in_data.alu_op)
            mse_pkg::ALU_ADD:  alu_value = in_data.opnd_a + in_data.opnd_2;
            mse_pkg::ALU_SUB:  alu_value = in_data.opnd_a - in_data.opnd_2;
            mse_pkg::ALU_AND:  alu_value = in_data.opnd_a & in_data.opnd_2;
            mse_pkg::ALU_OR:   alu_value = in_data.opnd_a | in_data.opnd_2;
            mse_pkg::ALU_NOR:  alu_value = ~(in_data.opnd_a | in_data.opnd_2);
            mse_pkg::ALU_SLTU: alu_value = {31'd0, in_data.opnd_a < in_data.opnd_2};
            mse_pkg::ALU_SLL:  alu_value = in_data.opnd_2 << in_data.shamt;
            mse_pkg::ALU_SRL:  alu_value = in_data.opnd_2 >> in_data.shamt;
            mse_pkg::ALU_PASS: alu_value = in_data.opnd_2;
            default:           alu_value = '0;
        endcase
    end

    // Branch compare and target
    always_comb
    begin
        data_next.alu_out     = alu_value;
        data_next.br_kind     = in_data.br_kind;
        data_next.equal       = (in_data.opnd_a == in_data.opnd_b);
        data_next.branch_addr = in_data.next_addr + in_data.br_offset;
        data_next.jump_taken  = in_data.jump_taken;
        data_next.jump_addr   = in_data.jump_addr;
        data_next.store_data  = in_data.opnd_b;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/mse_result_stage.sv =====
module mse_result_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mse_pkg::exe_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output mse_pkg::out_req_t out_data
);

    logic              valid_reg;
    mse_pkg::out_req_t data_reg;
    mse_pkg::out_req_t data_next;

    // Branch resolution and result assembly
    always_comb
    begin
        data_next.alu_out      = in_data.alu_out;
        data_next.branch_taken = ((in_data.br_kind == mse_pkg::BR_EQ) && in_data.equal) ||
                                 ((in_data.br_kind == mse_pkg::BR_NE) && !in_data.equal);
        data_next.branch_addr  = in_data.branch_addr;
        data_next.jump_taken   = in_data.jump_taken;
        data_next.jump_addr    = in_data.jump_addr;
        data_next.store_data   = in_data.store_data;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/mips_subset_execute_stage_top.sv =====
// Execute stage for a MIPS32 subset: takes one instruction request per clock while instr_ready
// is high and returns one result request per instruction, in order. A result passes through
// the three registered stages (operand select and decode, ALU and branch arithmetic, branch
// resolution into the output register); each stage holds its own valid bit and loads whenever
// it is empty or its successor takes its content, so bubbles close up under back-pressure and
// instr_ready stays high while any stage has room.
module mips_subset_execute_stage_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              instr_valid,
    output logic              instr_ready,
    input  mse_pkg::in_req_t  instr,
    output logic              result_valid,
    input  logic              result_ready,
    output mse_pkg::out_req_t result
);

    logic          dec_valid;
    logic          dec_ready;
    mse_pkg::dec_t dec_data;
    logic          exe_valid;
    logic          exe_ready;
    mse_pkg::exe_t exe_data;

    // Stage one: operand select and decode
    mse_operand_stage u_operand (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (instr_valid),
        .in_ready  (instr_ready),
        .in_req    (instr),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    // Stage two: ALU, compare, branch target
    mse_alu_stage u_alu (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (exe_valid),
        .out_ready (exe_ready),
        .out_data  (exe_data)
    );

    // Stage three: branch resolution, output register
    mse_result_stage u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (exe_valid),
        .in_ready  (exe_ready),
        .in_data   (exe_data),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

endmodule

// ===== rtl/mse_checker.sv =====
module mse_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              instr_valid,
    input logic              instr_ready,
    input mse_pkg::in_req_t  instr,
    input logic              result_valid,
    input logic              result_ready,
    input mse_pkg::out_req_t result
);

    // A held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while held");

    // An empty output stage means the whole pipe has room
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> instr_ready)
        else $error("input refused with an empty output stage");

    // Branch and jump never both raised
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.branch_taken && result.jump_taken))
        else $error("branch and jump both taken");

    // Control transfers carry no ALU result
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.branch_taken || result.jump_taken) |-> result.alu_out == '0)
        else $error("ALU result on a branch or jump");

    // No jump target without a jump
    a_jaddr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.jump_taken |-> result.jump_addr == '0)
        else $error("jump address without a jump");

endmodule

bind mips_subset_execute_stage_top mse_checker u_mse_checker (.*);

// ===== tb/mse_execute_checker.sv =====
// Watches both channels of the execute stage, predicts each result request from the
// instruction request that caused it and compares the two field by field.
module mse_execute_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              instr_valid,
    input  logic              instr_ready,
    input  mse_pkg::in_req_t  instr,
    input  logic              result_valid,
    input  logic              result_ready,
    input  mse_pkg::out_req_t result,
    output int                fail_count,
    output int                pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    out_req_t expected_results[$];

    // Operand source mux; codes two and three both pick the memory forward
    function automatic logic [31:0] select_operand(logic [1:0] sel, logic [31:0] reg_val,
                                                   logic [31:0] wb_val, logic [31:0] mem_val);
        if (sel == SEL_REG)
            return reg_val;
        if (sel == SEL_WB)
            return wb_val;
        return mem_val;
    endfunction

    // Expected result of one instruction request
    function automatic out_req_t predict_execute(in_req_t q);
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] sext;
        logic [31:0] zext;
        logic [31:0] next_pc;
        logic [5:0]  opcode;
        logic [5:0]  funct;
        logic [4:0]  shamt;
        out_req_t    r;
        opa     = select_operand(q.select_a, q.reg_value_a, q.wb_forward_value,
                                 q.mem_forward_value);
        opb     = select_operand(q.select_b, q.reg_value_b, q.wb_forward_value,
                                 q.mem_forward_value);
        opcode  = q.instr_word[31:26];
        funct   = q.instr_word[5:0];
        shamt   = q.instr_word[10:6];
        zext    = {16'h0000, q.instr_word[15:0]};
        sext    = {{16{q.instr_word[15]}}, q.instr_word[15:0]};
        next_pc = q.instr_addr + PC_STEP;

        r             = '0;
        r.branch_addr = next_pc + (sext << 2);
        r.store_data  = opb;

        case (opcode)
            OP_SPECIAL:
            begin
                case (funct)
                    FN_JR:
                    begin
                        r.jump_taken = 1'b1;
                        r.jump_addr  = opa;
                    end
                    FN_ADDU: r.alu_out = opa + opb;
                    FN_SUBU: r.alu_out = opa - opb;
                    FN_AND:  r.alu_out = opa & opb;
                    FN_OR:   r.alu_out = opa | opb;
                    FN_NOR:  r.alu_out = ~(opa | opb);
                    FN_SLTU: r.alu_out = {31'd0, opa < opb};
                    FN_SLL:  r.alu_out = opb << shamt;
                    FN_SRL:  r.alu_out = opb >> shamt;
                    default: r.alu_out = '0;
                endcase
            end
            OP_J, OP_JAL:
            begin
                r.jump_taken = 1'b1;
                r.jump_addr  = {next_pc[31:28], q.instr_word[25:0], 2'b00};
            end
            OP_BEQ: r.branch_taken = (opa == opb);
            OP_BNE: r.branch_taken = (opa != opb);
            OP_ADDIU, OP_LW, OP_SW: r.alu_out = opa + sext;
            // immediate sign-extended, then an unsigned compare
            OP_SLTIU: r.alu_out = {31'd0, opa < sext};
            OP_ANDI:  r.alu_out = opa & zext;
            OP_ORI:   r.alu_out = opa | zext;
            OP_LUI:   r.alu_out = {q.instr_word[15:0], 16'h0000};
            default:  r.alu_out = '0;
        endcase
        return r;
    endfunction

    function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    initial
    begin
        fail_count      = 0;
        pending_results = 0;
    end

    // Compare before queueing: a request taken at this edge cannot already be out
    always @(posedge clk)
    begin : watch
        out_req_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result request with nothing expected: %h", result);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    fail_count = fail_count
                        + field_mismatch("alu_out", want.alu_out, result.alu_out)
                        + field_mismatch("branch_taken", {31'd0, want.branch_taken},
                                         {31'd0, result.branch_taken})
                        + field_mismatch("branch_addr", want.branch_addr, result.branch_addr)
                        + field_mismatch("jump_taken", {31'd0, want.jump_taken},
                                         {31'd0, result.jump_taken})
                        + field_mismatch("jump_addr", want.jump_addr, result.jump_addr)
                        + field_mismatch("store_data", want.store_data, result.store_data);
                end
            end
            if (instr_valid && instr_ready)
                expected_results.push_back(predict_execute(instr));
            pending_results = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_mips_subset_execute_stage_top.sv =====
module tb_mips_subset_execute_stage_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    // Memory forward select and its duplicate code
    localparam logic [1:0] SEL_MEM     = 2'd2;
    localparam logic [1:0] SEL_MEM_ALT = 2'd3;
    // Codes the stage does not decode
    localparam logic [5:0] OP_UNUSED   = 6'h3F;
    localparam logic [5:0] FN_UNUSED   = 6'h3F;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      instr_valid  = 1'b0;
    logic      instr_ready;
    in_req_t   instr        = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_req_t  result;
    int        fail_count;
    int        pending_results;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    mips_subset_execute_stage_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .instr        (instr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    mse_execute_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .instr_valid     (instr_valid),
        .instr_ready     (instr_ready),
        .instr           (instr),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        else
            result_ready <= 1'b0;
    end

    function automatic logic [31:0] r_word(logic [5:0] funct, logic [4:0] shamt);
        return {OP_SPECIAL, 5'd3, 5'd7, 5'd9, shamt, funct};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] opcode, logic [15:0] imm);
        return {opcode, 5'd1, 5'd2, imm};
    endfunction

    function automatic logic [31:0] j_word(logic [5:0] opcode, logic [25:0] target);
        return {opcode, target};
    endfunction

    function automatic in_req_t mk_req(logic [31:0] word, logic [31:0] pc,
                                       logic [31:0] ra, logic [31:0] rb,
                                       logic [31:0] wb, logic [31:0] mem,
                                       logic [1:0] sa, logic [1:0] sb);
        in_req_t q;
        q.instr_word        = word;
        q.instr_addr        = pc;
        q.reg_value_a       = ra;
        q.reg_value_b       = rb;
        q.wb_forward_value  = wb;
        q.mem_forward_value = mem;
        q.select_a          = sa;
        q.select_b          = sb;
        return q;
    endfunction

    // Data values weighted towards the corners
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] rand_funct();
        case ($urandom_range(0, 9))
            0:       return FN_SLL;
            1:       return FN_SRL;
            2:       return FN_JR;
            3:       return FN_ADDU;
            4:       return FN_SUBU;
            5:       return FN_AND;
            6:       return FN_OR;
            7:       return FN_NOR;
            8:       return FN_SLTU;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [5:0] rand_opcode();
        case ($urandom_range(0, 10))
            0:       return OP_J;
            1:       return OP_JAL;
            2:       return OP_BEQ;
            3:       return OP_BNE;
            4:       return OP_ADDIU;
            5:       return OP_SLTIU;
            6:       return OP_ANDI;
            7:       return OP_ORI;
            8:       return OP_LUI;
            9:       return OP_LW;
            default: return OP_SW;
        endcase
    endfunction

    // Mostly decodable instructions with random content, some raw noise
    function automatic in_req_t random_instr_req();
        in_req_t     q;
        logic [31:0] w;
        int          kind;
        kind = $urandom_range(0, 19);
        w    = $urandom;
        if (kind < 8)
        begin
            w[31:26] = OP_SPECIAL;
            w[5:0]   = rand_funct();
        end
        else if (kind < 18)
        begin
            w[31:26] = rand_opcode();
            case ($urandom_range(0, 7))
                0:       w[15:0] = 16'h0000;
                1:       w[15:0] = 16'hFFFF;
                2:       w[15:0] = 16'h8000;
                3:       w[15:0] = 16'h7FFF;
                default: ;
            endcase
        end
        q = mk_req(w, rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        // make the operands equal now and then so that branches resolve both ways
        if ($urandom_range(0, 3) == 0)
        begin
            q.select_b    = q.select_a;
            q.reg_value_b = q.reg_value_a;
        end
        return q;
    endfunction

    // One instruction request through the handshake, with random idling first
    task automatic send_instr(in_req_t q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
        end
        instr_valid <= 1'b1;
        instr       <= q;
        @(posedge clk);
        while (!instr_ready)
            @(posedge clk);
    endtask

    // Hold the sender off until every expected result has come back
    task automatic drain_results();
        instr_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
        @(posedge clk);
    endtask

    task automatic send_random(int count);
        repeat (count)
            send_instr(random_instr_req());
    endtask

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 83;

        // Directed: every operation, field extremes and the corner cases
        send_instr(mk_req(r_word(FN_ADDU, 5'd0), 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(r_word(FN_SUBU, 5'd0), 32'h4, 32'h5, 32'h6, 32'h0, 32'h1,
                          SEL_WB, SEL_MEM));
        send_instr(mk_req(r_word(FN_AND, 5'd0), 32'h8, 32'h0, 32'hFFFF_0000, 32'h0,
                          32'hF0F0_F0F0, SEL_MEM_ALT, SEL_REG));
        send_instr(mk_req(r_word(FN_OR, 5'd0), 32'hC, 32'h0F0F_0F0F, 32'h0, 32'hF0F0_F0F0,
                          32'h0, SEL_REG, SEL_WB));
        send_instr(mk_req(r_word(FN_NOR, 5'd0), 32'h10, 32'h0, 32'h0, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(r_word(FN_SLTU, 5'd0), 32'h14, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(r_word(FN_SLTU, 5'd0), 32'h18, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(r_word(FN_SLL, 5'd31), 32'h1C, 32'h0, 32'h1, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(r_word(FN_SLL, 5'd0), 32'h20, 32'h0, 32'hDEAD_BEEF, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(r_word(FN_SRL, 5'd31), 32'h24, 32'h0, 32'h0, 32'h0, 32'h8000_0000,
                          SEL_REG, SEL_MEM_ALT));
        send_instr(mk_req(r_word(FN_JR, 5'd0), 32'h28, 32'hFFFF_FFFC, 32'h0, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(r_word(FN_UNUSED, 5'd31), 32'h2C, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'h0, 32'h0, SEL_REG, SEL_REG));
        send_instr(mk_req(j_word(OP_J, 26'h3FF_FFFF), 32'hF000_0000, 32'h0, 32'h0, 32'h0,
                          32'h0, SEL_REG, SEL_REG));
        send_instr(mk_req(j_word(OP_JAL, 26'h0), 32'hFFFF_FFFC, 32'h0, 32'h0, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_BEQ, 16'h7FFF), 32'h30, 32'h1234, 32'h0, 32'h0, 32'h1234,
                          SEL_REG, SEL_MEM));
        send_instr(mk_req(i_word(OP_BEQ, 16'h8000), 32'h34, 32'h1234, 32'h1235, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_BNE, 16'hFFFF), 32'h0, 32'h0, 32'h0, 32'h77, 32'h77,
                          SEL_WB, SEL_MEM_ALT));
        send_instr(mk_req(i_word(OP_BNE, 16'h0000), 32'hFFFF_FFFC, 32'h1, 32'h2, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_ADDIU, 16'h8000), 32'h38, 32'h0, 32'h0, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_SLTIU, 16'hFFFF), 32'h3C, 32'hFFFF_FFFE, 32'h0, 32'h0,
                          32'h0, SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_ANDI, 16'hFFFF), 32'h40, 32'hFFFF_FFFF, 32'h0, 32'h0,
                          32'h0, SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_ORI, 16'hFFFF), 32'h44, 32'h0, 32'h0, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_LUI, 16'hFFFF), 32'h48, 32'h0, 32'h0, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_LW, 16'hFFFC), 32'h4C, 32'h1000, 32'h0, 32'h0, 32'h0,
                          SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_SW, 16'h0004), 32'h50, 32'hFFFF_FFFE, 32'hCAFE_F00D,
                          32'h0, 32'h0, SEL_REG, SEL_REG));
        send_instr(mk_req(i_word(OP_UNUSED, 16'hFFFF), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'h0, 32'h0, SEL_REG, SEL_REG));

        // Pipeline empties completely before the random part
        drain_results();

        send_random(370);

        send_idle_pct = 83;
        recv_idle_pct = 26;
        send_random(370);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(360);

        // Wait out the last results, then keep clocking to catch anything stray
        drain_results();
        repeat (10)
            @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
